>>> sv/assert_macros.svh
// assertion macros shared by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is low
`define CDA_ASSERT_RST(name, clk, rst_n, prop) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("calendar date adder check failed");

// clocked assertion that also holds during reset
`define CDA_ASSERT(name, clk, prop) \
	name: assert property (@(posedge clk) prop) \
		else $error("calendar date adder check failed");

`endif

>>> sv/cda_pkg.sv
// shared types, constants and month table for the calendar date adder
`timescale 1ns / 1ps
`default_nettype none

package cda_pkg;

	localparam int YEAR_W  = 14;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int INC_W   = 16;

	localparam logic [YEAR_W-1:0]  YEAR_MAX    = 14'd9999;
	localparam logic [YEAR_W-1:0]  RESET_YEAR  = 14'd1111;
	localparam logic [MONTH_W-1:0] RESET_MONTH = 4'd1;
	localparam logic [DAY_W-1:0]   RESET_DAY   = 5'd1;
	// 1111 mod 25
	localparam logic [4:0]         RESET_REM25 = 5'd11;

	localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
	localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
	localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
	localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
	localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
	localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
	localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

	localparam logic [DAY_W-1:0] LEN_LONG     = 5'd31;
	localparam logic [DAY_W-1:0] LEN_SHORT    = 5'd30;
	localparam logic [DAY_W-1:0] LEN_FEB_LEAP = 5'd29;
	localparam logic [DAY_W-1:0] LEN_FEB      = 5'd28;
	localparam logic [DAY_W-1:0] FIRST_DAY    = 5'd1;

	// y / 25 == (y * RECIP25) >> RECIP25_SH for every 14-bit y
	localparam logic [12:0] RECIP25    = 13'd5243;
	localparam int          RECIP25_SH = 17;
	localparam int          QUOT_W     = 10;
	localparam logic [4:0]  REM25_TOP  = 5'd24;

	typedef enum logic {
		OP_SET = 1'b0,
		OP_ADD = 1'b1
	} cda_op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_REM,
		ST_WALK,
		ST_DONE
	} cda_state_t;

	typedef struct packed {
		logic               operation;
		logic [YEAR_W-1:0]  new_year;
		logic [MONTH_W-1:0] new_month;
		logic [DAY_W-1:0]   new_day;
		logic [INC_W-1:0]   day_increment;
	} cda_req_t;

	typedef struct packed {
		logic [YEAR_W-1:0]  out_year;
		logic [MONTH_W-1:0] out_month;
		logic [DAY_W-1:0]   out_day;
		logic               year_overflow;
	} cda_rsp_t;

	// months outside 1..12 count as long months
	function automatic logic [DAY_W-1:0] cda_month_len(input logic [MONTH_W-1:0] m,
		input logic leap);
		logic [DAY_W-1:0] len;
		case (m)
			MONTH_FEB: len = leap ? LEN_FEB_LEAP : LEN_FEB;
			MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = LEN_SHORT;
			default: len = LEN_LONG;
		endcase
		return len;
	endfunction

endpackage

`default_nettype wire

>>> sv/calendar_date_adder.sv
// calendar date register with set and add-days, one month stepped per cycle
//
//  channel | dir | handshake            | word
//  --------+-----+----------------------+----------------------------------
//  req     | in  | req_valid/req_stall  | op, new y/m/d, day increment
//  rsp     | out | rsp_valid/rsp_stall  | year, month, day, year_overflow
//
// set: passes through ST_REM (year mod 25 is rebuilt for the leap rule), then ST_DONE
// add: passes through ST_WALK, where the month walker crosses the months one by one, then ST_DONE
// an add of zero days skips the walker and goes straight to ST_DONE
// the walker unit (month length, day compare, increment subtract) and the year mod 25 unit form the datapath
// reset leaves 1111-01-01; a held result in rsp does not block the next request
`timescale 1ns / 1ps
`default_nettype none

module calendar_date_adder import cda_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     req_valid,
	output      logic     req_stall,
	input  wire cda_req_t req,
	output      logic     rsp_valid,
	input  wire logic     rsp_stall,
	output      cda_rsp_t rsp
);

	cda_state_t state_q, state_d;

	logic [YEAR_W-1:0]  year_q;
	logic [MONTH_W-1:0] month_q;
	logic [DAY_W-1:0]   day_q;
	logic [4:0]         rem25_q;
	logic [QUOT_W-1:0]  quot_q;
	logic [INC_W-1:0]   inc_q;
	logic               ovf_q;
	logic               rsp_valid_q;
	cda_rsp_t           rsp_q;

	logic accept;
	logic rsp_free;
	logic finish;

	// walker signals
	logic                leap;
	logic [DAY_W-1:0]    len;
	logic [INC_W:0]      day_sum;
	logic                fits;
	logic [DAY_W-1:0]    day_clip;
	logic [DAY_W:0]      step;
	logic                wrap;
	logic                saturate;
	logic                walk_done;
	logic [INC_W-1:0]    inc_next;
	logic [26:0]         quot_prod;
	logic [YEAR_W-1:0]   quot_x25;
	logic [YEAR_W-1:0]   rem_wide;

	// fsm outputs
	always_comb begin
		req_stall = (state_q != ST_IDLE);
		accept    = req_valid && (state_q == ST_IDLE);
		rsp_free  = !rsp_valid_q || !rsp_stall;
		finish    = (state_q == ST_DONE) && rsp_free;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (req.operation == OP_SET)
						state_d = ST_REM;
					else if (req.day_increment == '0)
						state_d = ST_DONE;
					else
						state_d = ST_WALK;
				end
			end
			ST_REM:  state_d = ST_DONE;
			ST_WALK: begin
				if (walk_done)
					state_d = ST_DONE;
			end
			ST_DONE: begin
				if (rsp_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// div by 400 == div by 16 and by 25
	assign leap      = (year_q[1:0] == 2'd0) && ((rem25_q != 5'd0) || (year_q[3:0] == 4'd0));
	assign len       = cda_month_len(month_q, leap);
	assign day_sum   = {{(INC_W+1-DAY_W){1'b0}}, day_q} + {1'b0, inc_q};
	assign fits      = (day_q <= len) && (day_sum <= {{(INC_W+1-DAY_W){1'b0}}, len});
	assign day_clip  = (day_q > len) ? len : day_q;
	assign step      = {1'b0, len} - {1'b0, day_clip} + {{DAY_W{1'b0}}, 1'b1};
	assign inc_next  = inc_q - {{(INC_W-DAY_W-1){1'b0}}, step};
	assign wrap      = (month_q >= MONTH_DEC);
	assign saturate  = !fits && wrap && (year_q >= YEAR_MAX);
	assign walk_done = fits || saturate;

	assign quot_prod = req.new_year * RECIP25;
	assign quot_x25  = {quot_q, 4'd0} + {1'b0, quot_q, 3'd0} + {4'd0, quot_q};
	assign rem_wide  = year_q - quot_x25;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			year_q      <= RESET_YEAR;
			month_q     <= RESET_MONTH;
			day_q       <= RESET_DAY;
			rem25_q     <= RESET_REM25;
			ovf_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				ovf_q <= 1'b0;
				if (req.operation == OP_SET) begin
					year_q  <= req.new_year;
					month_q <= req.new_month;
					day_q   <= req.new_day;
				end
			end
			if (state_q == ST_REM)
				rem25_q <= rem_wide[4:0];
			if (state_q == ST_WALK) begin
				if (fits) begin
					day_q <= day_sum[DAY_W-1:0];
				end else if (saturate) begin
					year_q  <= YEAR_MAX;
					month_q <= MONTH_DEC;
					day_q   <= LEN_LONG;
					ovf_q   <= 1'b1;
				end else begin
					day_q <= FIRST_DAY;
					if (wrap) begin
						year_q  <= year_q + 14'd1;
						month_q <= MONTH_JAN;
						rem25_q <= (rem25_q == REM25_TOP) ? 5'd0 : rem25_q + 5'd1;
					end else begin
						month_q <= month_q + 4'd1;
					end
				end
			end
			if (finish)
				rsp_valid_q <= 1'b1;
			else if (!rsp_stall)
				rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			inc_q  <= req.day_increment;
			quot_q <= quot_prod[RECIP25_SH +: QUOT_W];
		end else if (state_q == ST_WALK) begin
			inc_q <= inc_next;
		end
		if (finish) begin
			rsp_q.out_year      <= year_q;
			rsp_q.out_month     <= month_q;
			rsp_q.out_day       <= day_q;
			rsp_q.year_overflow <= ovf_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

>>> sv/cda_checker.sv
// port-level checks for the calendar date adder, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module cda_checker import cda_pkg::*; (
	input wire logic     clk,
	input wire logic     arst_n,
	input wire logic     req_valid,
	input wire logic     req_stall,
	input wire cda_req_t req,
	input wire logic     rsp_valid,
	input wire logic     rsp_stall,
	input wire cda_rsp_t rsp
);

	// a taken request keeps the block busy on the next cycle
	`CDA_ASSERT_RST(a_busy_after_accept, clk, arst_n, req_valid && !req_stall |=> req_stall)

	// a stalled result word holds
	`CDA_ASSERT_RST(a_rsp_hold, clk, arst_n, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))

	// saturation always lands on the last day of the last year
	`CDA_ASSERT(a_ovf_date, clk, rsp_valid && rsp.year_overflow |-> rsp.out_year == YEAR_MAX && rsp.out_month == MONTH_DEC && rsp.out_day == LEN_LONG)

	// a new result only shows up while a request was in flight
	`CDA_ASSERT_RST(a_rsp_from_work, clk, arst_n, $rose(rsp_valid) |-> $past(req_stall))

endmodule

bind calendar_date_adder cda_checker u_cda_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

`default_nettype wire

>>> test/calendar_date_monitor.sv
// checker for the calendar date adder: tracks the held date, predicts each result word, compares
`timescale 1ns / 1ps

module calendar_date_monitor import cda_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	input  logic     req_stall,
	input  cda_req_t req,
	input  logic     rsp_valid,
	input  logic     rsp_stall,
	input  cda_rsp_t rsp,
	output int       fail_count,
	output int       pending
);

	logic [YEAR_W-1:0]  held_year;
	logic [MONTH_W-1:0] held_month;
	logic [DAY_W-1:0]   held_day;
	cda_rsp_t           expected_dates[$];

	function automatic bit leap_year(input logic [YEAR_W-1:0] y);
		return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
	endfunction

	// months outside the calendar count as 31 days
	function automatic int month_days(input logic [YEAR_W-1:0] y,
		input logic [MONTH_W-1:0] m);
		if (m < MONTH_JAN || m > MONTH_DEC)
			return int'(LEN_LONG);
		if (m == MONTH_FEB)
			return leap_year(y) ? int'(LEN_FEB_LEAP) : int'(LEN_FEB);
		if (m == MONTH_APR || m == MONTH_JUN || m == MONTH_SEP || m == MONTH_NOV)
			return int'(LEN_SHORT);
		return int'(LEN_LONG);
	endfunction

	// applies one request word to the held date and returns the result word
	function automatic cda_rsp_t advance_held_date(input cda_req_t w);
		int       left;
		int       len;
		int       d;
		cda_rsp_t r;
		r.year_overflow = 1'b0;
		if (w.operation == OP_SET) begin
			held_year  = w.new_year;
			held_month = w.new_month;
			held_day   = w.new_day;
		end else begin
			left = int'(w.day_increment);
			while (left != 0) begin
				len = month_days(held_year, held_month);
				d   = int'(held_day);
				if (d <= len && d + left <= len) begin
					held_day = DAY_W'(d + left);
					left     = 0;
				end else begin
					// a day past the month end counts as its last day
					if (d > len)
						d = len;
					left     = left - (len - d + 1);
					held_day = FIRST_DAY;
					if (held_month >= MONTH_DEC) begin
						if (held_year >= YEAR_MAX) begin
							held_year       = YEAR_MAX;
							held_month      = MONTH_DEC;
							held_day        = LEN_LONG;
							r.year_overflow = 1'b1;
							left            = 0;
						end else begin
							held_year  = held_year + 1'b1;
							held_month = MONTH_JAN;
						end
					end else begin
						held_month = held_month + 1'b1;
					end
				end
			end
		end
		r.out_year  = held_year;
		r.out_month = held_month;
		r.out_day   = held_day;
		return r;
	endfunction

	function automatic void check_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			fail_count = fail_count + 1;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		cda_rsp_t want;
		if (!arst_n) begin
			held_year  = RESET_YEAR;
			held_month = RESET_MONTH;
			held_day   = RESET_DAY;
			expected_dates.delete();
			fail_count = 0;
			pending    = 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (expected_dates.size() == 0) begin
					$display("%0t: unexpected result word %0d-%0d-%0d overflow %0d", $time,
						rsp.out_year, rsp.out_month, rsp.out_day, rsp.year_overflow);
					fail_count = fail_count + 1;
				end else begin
					want = expected_dates.pop_front();
					check_field("out_year", int'(want.out_year), int'(rsp.out_year));
					check_field("out_month", int'(want.out_month), int'(rsp.out_month));
					check_field("out_day", int'(want.out_day), int'(rsp.out_day));
					check_field("year_overflow", int'(want.year_overflow),
						int'(rsp.year_overflow));
				end
			end
			if (req_valid && !req_stall)
				expected_dates.push_back(advance_held_date(req));
			pending = expected_dates.size();
		end
	end

endmodule

>>> test/tb_calendar_date_adder.sv
// testbench top for the calendar date adder: clock, reset, request words, stalls, verdict
`timescale 1ns / 1ps

module tb_calendar_date_adder import cda_pkg::*; ();

	localparam int CLK_PERIOD     = 8;
	localparam int RESET_CYCLES   = 5;
	localparam int RANDOM_ITEMS   = 250;
	// slowest add walks about 2160 months, plus response stalls
	localparam int WATCHDOG_LIMIT = 25000;
	localparam int TAIL_CYCLES    = 40;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       req_valid = 1'b0;
	logic       req_stall;
	cda_req_t   req       = '0;
	logic       rsp_valid;
	logic       rsp_stall = 1'b0;
	cda_rsp_t   rsp;
	int         fail_count;
	int         pending;
	int         idle_cycles = 0;
	int         burst_left  = 0;
	int         stall_left  = 0;
	logic [1:0] stall_mode  = 2'd0;

	calendar_date_adder DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	calendar_date_monitor date_monitor (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp        (rsp),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// unused fields carry random bits
	function automatic cda_req_t make_set(input int y, input int m, input int d);
		cda_req_t w;
		w.operation     = OP_SET;
		w.new_year      = YEAR_W'(y);
		w.new_month     = MONTH_W'(m);
		w.new_day       = DAY_W'(d);
		w.day_increment = INC_W'($urandom_range(0, 65535));
		return w;
	endfunction

	function automatic cda_req_t make_add(input int inc);
		cda_req_t w;
		w.operation     = OP_ADD;
		w.new_year      = YEAR_W'($urandom_range(0, 16383));
		w.new_month     = MONTH_W'($urandom_range(0, 15));
		w.new_day       = DAY_W'($urandom_range(0, 31));
		w.day_increment = INC_W'(inc);
		return w;
	endfunction

	// mostly short steps, a few long walks
	function automatic int rand_increment();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return $urandom_range(0, 40);
		if (r < 85)
			return $urandom_range(0, 400);
		if (r < 96)
			return $urandom_range(0, 4000);
		return $urandom_range(0, 65535);
	endfunction

	task automatic send_date_word(input cda_req_t w);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
			if (gap != 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 12);
		end
		req       <= w;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		@(negedge clk);
		burst_left = burst_left - 1;
	endtask

	// hold off until every result word has come back
	task automatic drain_results();
		req_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
	endtask

	// receiver stalls in phases: none, light, half, heavy
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= 2'($urandom_range(0, 3));
			stall_left <= $urandom_range(8, 64);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			2'd0: rsp_stall <= 1'b0;
			2'd1: rsp_stall <= ($urandom_range(0, 3) == 0);
			2'd2: rsp_stall <= ($urandom_range(0, 1) == 0);
			default: rsp_stall <= ($urandom_range(0, 7) != 0);
		endcase
	end

	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("tb_calendar_date_adder NOT OK");
				$finish;
			end
		end
	end

	initial begin
		int  sent;
		int  y;
		int  m;
		int  d;
		int  r;
		bit  paused;
		sent   = 0;
		paused = 1'b0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset date, zero and single-day steps
		send_date_word(make_add(0));
		send_date_word(make_add(1));
		// leap rule: every fourth year, not centuries, but every fourth century
		send_date_word(make_set(2000, 2, 28));
		send_date_word(make_add(1));
		send_date_word(make_add(1));
		send_date_word(make_set(1900, 2, 28));
		send_date_word(make_add(1));
		send_date_word(make_set(0, 2, 28));
		send_date_word(make_add(1));
		// months outside the calendar
		send_date_word(make_set(2021, 0, 5));
		send_date_word(make_add(30));
		send_date_word(make_set(2021, 13, 10));
		send_date_word(make_add(25));
		send_date_word(make_set(2021, 15, 31));
		send_date_word(make_add(1));
		// day zero and day past month end
		send_date_word(make_set(2021, 3, 0));
		send_date_word(make_add(1));
		send_date_word(make_set(2021, 4, 31));
		send_date_word(make_add(1));
		// year rollover into saturation, and a held year already past the top
		send_date_word(make_set(9998, 12, 31));
		send_date_word(make_add(400));
		send_date_word(make_set(16383, 12, 31));
		send_date_word(make_add(1));
		// longest walk
		send_date_word(make_set(2000, 1, 1));
		send_date_word(make_add(65535));

		while (sent < RANDOM_ITEMS) begin
			if (!paused && sent >= RANDOM_ITEMS / 2) begin
				drain_results();
				paused = 1'b1;
			end
			if ($urandom_range(0, 9) == 0) begin
				if ($urandom_range(0, 1) == 0)
					send_date_word(make_set($urandom_range(0, 16383), $urandom_range(0, 15),
						$urandom_range(0, 31)));
				else
					send_date_word(make_add(rand_increment()));
				sent = sent + 1;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 20)
					y = 100 * $urandom_range(15, 25) - $urandom_range(0, 1);
				else if (r < 35)
					y = $urandom_range(9990, 9999);
				else if (r < 40)
					y = $urandom_range(0, 16383);
				else
					y = $urandom_range(1, 9999);
				// 16 wraps to month zero
				m = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 16) : $urandom_range(1, 12);
				r = $urandom_range(0, 99);
				if (r < 60)
					d = $urandom_range(1, 28);
				else if (r < 85)
					d = $urandom_range(28, 31);
				else
					d = $urandom_range(0, 31);
				send_date_word(make_set(y, m, d));
				sent = sent + 1;
				repeat ($urandom_range(1, 8)) begin
					send_date_word(make_add(rand_increment()));
					sent = sent + 1;
				end
			end
		end

		drain_results();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("tb_calendar_date_adder OK");
		else
			$display("tb_calendar_date_adder NOT OK");
		$finish;
	end

endmodule
